FILE: src/lzjb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzjb_pkg: shared constants and types of the lzjb decompressor
// Field widths, stream format constants, parser and engine state encodings.
// ----------------------------------------------------------------------------
package lzjb_pkg;

  // decompressed bytes packed into one output word
  localparam int OUT_WORD_BYTES = 8;
  localparam int OUT_BITS       = 8 * OUT_WORD_BYTES;
  localparam int CNT_W          = 4;

  // block length and position counters
  localparam int LENGTH_BITS = 21;

  // stream format
  localparam int LEN_FIELD_BITS  = 6;
  localparam int DIST_FIELD_BITS = 10;
  localparam int MIN_COPY        = 3;
  localparam int RUN_W           = LEN_FIELD_BITS + 1;
  localparam int MAP_BITS        = 8;
  localparam int MAP_LEFT_W      = 4;

  // history window
  localparam int WIN_AW    = 10;
  localparam int WIN_DEPTH = 1 << WIN_AW;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_REF  = 2'd1,
    ST_PAST_END = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PH_MAP  = 2'd0,
    PH_ITEM = 2'd1,
    PH_LOW  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_LIT  = 2'd1,
    CMD_COPY = 2'd2,
    CMD_ERR  = 2'd3
  } cmd_kind_e;

  typedef enum logic [1:0] {
    ES_IDLE = 2'd0,
    ES_COPY = 2'd1,
    ES_EMIT = 2'd2
  } eng_state_e;

  // decoded work handed from the parser to the copy engine
  typedef struct packed {
    cmd_kind_e                  kind;
    logic [7:0]                 lit;
    logic [DIST_FIELD_BITS-1:0] copy_dist;
    logic [RUN_W-1:0]           run;
    status_e                    status;
  } cmd_t;

endpackage

FILE: src/lzjb_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzjb_ifs: stream channels of the lzjb decompressor
// Compressed byte input channel and packed output word channel.
// ----------------------------------------------------------------------------
interface lzjb_in_if import lzjb_pkg::*;;
  logic       valid;
  logic       ready;
  logic [7:0] compressed_byte;
  logic       block_start;

  modport source (output valid, compressed_byte, block_start, input ready);
  modport sink   (input valid, compressed_byte, block_start, output ready);
endinterface

interface lzjb_out_if import lzjb_pkg::*;;
  logic                valid;
  logic                ready;
  logic [OUT_BITS-1:0] out_bytes;
  logic [CNT_W-1:0]    byte_count;
  logic                last_of_run;
  logic                block_done;
  logic [1:0]          status;

  modport source (output valid, out_bytes, byte_count, last_of_run, block_done, status,
                  input ready);
  modport sink   (input valid, out_bytes, byte_count, last_of_run, block_done, status,
                  output ready);
endinterface

FILE: src/lzjb_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzjb_parse: compressed stream parser
// Tracks map bits and token bytes, checks references and lengths, and hands
// literal, copy or error commands to the copy engine.
// ----------------------------------------------------------------------------
module lzjb_parse import lzjb_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [7:0]             byte_i,
  input  logic                   block_start_i,
  input  logic [LENGTH_BITS-1:0] pos_i,
  input  logic [LENGTH_BITS-1:0] len_i,
  output cmd_t                   cmd_o
);

  logic [MAP_BITS-1:0]   map_q, map_d, map_eff;
  logic [MAP_LEFT_W-1:0] left_q, left_d, left_eff, left_cons;
  phase_e                phase_q, phase_d, phase_eff;
  logic [7:0]            tok_q, tok_d, tok_eff;
  logic                  err_q, err_d, err_eff;
  logic                  ignore;
  logic [DIST_FIELD_BITS-1:0] copy_dist;
  logic [RUN_W-1:0]      run;

  // block start clears the parse state before the byte is looked at
  always_comb begin
    map_eff   = block_start_i ? '0 : map_q;
    left_eff  = block_start_i ? '0 : left_q;
    phase_eff = block_start_i ? PH_MAP : phase_q;
    tok_eff   = block_start_i ? '0 : tok_q;
    err_eff   = block_start_i ? 1'b0 : err_q;
    ignore    = err_eff || (pos_i >= len_i);
    left_cons = (left_eff != '0) ? left_eff - MAP_LEFT_W'(1) : left_eff;
    copy_dist = {tok_eff[1:0], byte_i};
    run       = RUN_W'(tok_eff[7:2]) + RUN_W'(MIN_COPY);
  end

  // parse step
  always_comb begin
    map_d           = map_q;
    left_d          = left_q;
    phase_d         = phase_q;
    tok_d           = tok_q;
    err_d           = err_q;
    cmd_o.kind      = CMD_NONE;
    cmd_o.lit       = byte_i;
    cmd_o.copy_dist = copy_dist;
    cmd_o.run       = run;
    cmd_o.status    = ST_OK;
    if (accept_i) begin
      map_d   = map_eff;
      left_d  = left_eff;
      phase_d = phase_eff;
      tok_d   = tok_eff;
      err_d   = err_eff;
      if (!ignore) begin
        case (phase_eff)
          PH_ITEM: begin
            if (map_eff[0]) begin
              tok_d   = byte_i;
              phase_d = PH_LOW;
            end else begin
              cmd_o.kind = CMD_LIT;
              map_d      = map_eff >> 1;
              left_d     = left_cons;
              phase_d    = (left_cons == '0) ? PH_MAP : PH_ITEM;
            end
          end
          PH_LOW: begin
            map_d   = map_eff >> 1;
            left_d  = left_cons;
            phase_d = (left_cons == '0) ? PH_MAP : PH_ITEM;
            if ((copy_dist == '0) || (LENGTH_BITS'(copy_dist) > pos_i)) begin
              cmd_o.kind   = CMD_ERR;
              cmd_o.status = ST_BAD_REF;
              err_d        = 1'b1;
            end else if (({1'b0, pos_i} + (LENGTH_BITS + 1)'(run)) > {1'b0, len_i}) begin
              cmd_o.kind   = CMD_ERR;
              cmd_o.status = ST_PAST_END;
              err_d        = 1'b1;
            end else begin
              cmd_o.kind = CMD_COPY;
            end
          end
          default: begin
            map_d   = byte_i;
            left_d  = MAP_LEFT_W'(MAP_BITS);
            phase_d = PH_ITEM;
          end
        endcase
      end
    end
  end

  // parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q   <= '0;
      left_q  <= '0;
      phase_q <= PH_MAP;
      tok_q   <= '0;
      err_q   <= 1'b0;
    end else begin
      map_q   <= map_d;
      left_q  <= left_d;
      phase_q <= phase_d;
      tok_q   <= tok_d;
      err_q   <= err_d;
    end
  end

endmodule

FILE: src/lzjb_decompressor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzjb_decompressor: streaming lzjb decompressor
// Parses the compressed byte stream, replays copies from a 1024-byte history
// memory and delivers decompressed bytes packed up to eight per word.
// ----------------------------------------------------------------------------
// Flow: a map byte or a token high byte is only accepted; a literal or an error
// is accepted, then its word is handed off; a copy is replayed through the
// single read port of the history memory, which delivers one byte per cycle
// as a registered read and pauses after each full eight-byte word while it is
// handed off. A word waiting at the output holds the engine until it is taken.
// The history memory is not cleared after reset (no clearing pass) since a
// block only ever reads what it has itself written.
// output_length is written by the user while the block is idle; the block
// does not enforce it. A block start byte restarts counters and parse state.
// ----------------------------------------------------------------------------
module lzjb_decompressor import lzjb_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [LENGTH_BITS-1:0] cfg_wdata_i,
  lzjb_in_if.sink                in_i,
  lzjb_out_if.source             out_o
);

  eng_state_e             state_q, state_d;
  logic [LENGTH_BITS-1:0] pos_q, pos_d, pos_eff;
  logic [LENGTH_BITS-1:0] len_q;
  logic [OUT_BITS-1:0]    acc_q, acc_d;
  logic [CNT_W-1:0]       acc_cnt_q, acc_cnt_d, acc_slots;
  logic [RUN_W-1:0]       copy_left_q, copy_left_d;
  logic [WIN_AW-1:0]      src_q, src_d;
  logic                   dist_one_q, dist_one_d;
  logic                   inflight_q;
  logic                   have_last_q, have_last_d;
  logic [7:0]             last_q, last_d, arr_byte;
  status_e                stat_q, stat_d;
  logic [7:0]             rdata_q;

  logic                   out_valid_q, out_valid_d;
  logic [OUT_BITS-1:0]    out_bytes_q, out_bytes_d;
  logic [CNT_W-1:0]       out_cnt_q, out_cnt_d;
  logic                   out_last_q, out_last_d;
  logic                   out_done_q, out_done_d;
  status_e                out_stat_q, out_stat_d;

  logic                   in_rdy, accept, rd_en, emit_ok, emit_mid, emit_last;
  logic                   wr_en;
  logic [WIN_AW-1:0]      wr_addr;
  logic [7:0]             wr_data;
  cmd_t                   cmd;

  logic [7:0]             hist_mem [WIN_DEPTH];

  assign accept  = in_i.valid && in_rdy;
  assign pos_eff = in_i.block_start ? '0 : pos_q;

  // stream parser
  lzjb_parse u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .byte_i        (in_i.compressed_byte),
    .block_start_i (in_i.block_start),
    .pos_i         (pos_eff),
    .len_i         (len_q),
    .cmd_o         (cmd)
  );

  // engine next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ES_IDLE: begin
        if (cmd.kind == CMD_COPY) begin
          state_d = ES_COPY;
        end else if ((cmd.kind == CMD_LIT) || (cmd.kind == CMD_ERR)) begin
          state_d = ES_EMIT;
        end
      end
      ES_COPY: begin
        if ((copy_left_q == '0) && !inflight_q) begin
          state_d = ES_EMIT;
        end
      end
      ES_EMIT: begin
        if (emit_ok) begin
          state_d = ES_IDLE;
        end
      end
      default: state_d = ES_IDLE;
    endcase
  end

  // engine control outputs
  always_comb begin
    acc_slots = acc_cnt_q + CNT_W'(inflight_q);
    emit_ok   = !out_valid_q || out_o.ready;
    in_rdy    = (state_q == ES_IDLE);
    rd_en     = (state_q == ES_COPY) && (copy_left_q != '0) &&
                (acc_slots < CNT_W'(OUT_WORD_BYTES));
    emit_mid  = (state_q == ES_COPY) && (acc_cnt_q == CNT_W'(OUT_WORD_BYTES)) &&
                (copy_left_q != '0) && emit_ok;
    emit_last = (state_q == ES_EMIT) && emit_ok;
  end

  // distance one repeats the previous byte, whose write may still be pending
  assign arr_byte = (dist_one_q && have_last_q) ? last_q : rdata_q;

  // datapath: command start, copy issue, byte arrival, word hand-off
  always_comb begin
    pos_d       = pos_q;
    acc_d       = acc_q;
    acc_cnt_d   = acc_cnt_q;
    copy_left_d = copy_left_q;
    src_d       = src_q;
    dist_one_d  = dist_one_q;
    have_last_d = have_last_q;
    last_d      = last_q;
    stat_d      = stat_q;
    wr_en       = 1'b0;
    wr_addr     = pos_q[WIN_AW-1:0];
    wr_data     = arr_byte;
    out_valid_d = out_valid_q;
    out_bytes_d = out_bytes_q;
    out_cnt_d   = out_cnt_q;
    out_last_d  = out_last_q;
    out_done_d  = out_done_q;
    out_stat_d  = out_stat_q;

    // new command from the parser
    if (accept) begin
      pos_d = pos_eff;
      case (cmd.kind)
        CMD_LIT: begin
          wr_en     = 1'b1;
          wr_addr   = pos_eff[WIN_AW-1:0];
          wr_data   = cmd.lit;
          pos_d     = pos_eff + LENGTH_BITS'(1);
          acc_d     = OUT_BITS'(cmd.lit);
          acc_cnt_d = CNT_W'(1);
          stat_d    = ST_OK;
        end
        CMD_COPY: begin
          copy_left_d = cmd.run;
          src_d       = pos_eff[WIN_AW-1:0] - cmd.copy_dist;
          dist_one_d  = (cmd.copy_dist == DIST_FIELD_BITS'(1));
          have_last_d = 1'b0;
          acc_d       = '0;
          acc_cnt_d   = '0;
          stat_d      = ST_OK;
        end
        CMD_ERR: begin
          acc_d     = '0;
          acc_cnt_d = '0;
          stat_d    = cmd.status;
        end
        default: ;
      endcase
    end

    // history read issue
    if (rd_en) begin
      src_d       = src_q + WIN_AW'(1);
      copy_left_d = copy_left_q - RUN_W'(1);
    end

    // copied byte arrives: write back and pack
    if (inflight_q) begin
      wr_en       = 1'b1;
      wr_addr     = pos_q[WIN_AW-1:0];
      wr_data     = arr_byte;
      pos_d       = pos_q + LENGTH_BITS'(1);
      last_d      = arr_byte;
      have_last_d = 1'b1;
      acc_cnt_d   = acc_cnt_q + CNT_W'(1);
      for (int i = 0; i < OUT_WORD_BYTES; i++) begin
        if (acc_cnt_q == CNT_W'(i)) begin
          acc_d[i*8 +: 8] = arr_byte;
        end
      end
    end

    // output register
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (emit_mid || emit_last) begin
      out_valid_d = 1'b1;
      out_bytes_d = acc_q;
      out_cnt_d   = acc_cnt_q;
      out_last_d  = emit_last;
      out_done_d  = (stat_q == ST_OK) && (pos_q >= len_q);
      out_stat_d  = stat_q;
      acc_d       = '0;
      acc_cnt_d   = '0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ES_IDLE;
      pos_q       <= '0;
      len_q       <= '0;
      acc_cnt_q   <= '0;
      copy_left_q <= '0;
      inflight_q  <= 1'b0;
      have_last_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      acc_cnt_q   <= acc_cnt_d;
      copy_left_q <= copy_left_d;
      inflight_q  <= rd_en;
      have_last_q <= have_last_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    acc_q       <= acc_d;
    src_q       <= src_d;
    dist_one_q  <= dist_one_d;
    last_q      <= last_d;
    stat_q      <= stat_d;
    out_bytes_q <= out_bytes_d;
    out_cnt_q   <= out_cnt_d;
    out_last_q  <= out_last_d;
    out_done_q  <= out_done_d;
    out_stat_q  <= out_stat_d;
  end

  // history window memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hist_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= hist_mem[src_q];
    end
  end

  // channel outputs
  assign in_i.ready        = in_rdy;
  assign out_o.valid       = out_valid_q;
  assign out_o.out_bytes   = out_bytes_q;
  assign out_o.byte_count  = out_cnt_q;
  assign out_o.last_of_run = out_last_q;
  assign out_o.block_done  = out_done_q;
  assign out_o.status      = out_stat_q;

endmodule

FILE: src/lzjb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzjb_checker: port level checks of the lzjb decompressor
// Watches the output channel for word shape rules and stall behaviour.
// ----------------------------------------------------------------------------
module lzjb_checker import lzjb_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [OUT_BITS-1:0] out_bytes_i,
  input logic [CNT_W-1:0]    byte_count_i,
  input logic                last_of_run_i,
  input logic                block_done_i,
  input logic [1:0]          status_i
);

  // a stalled word keeps its bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_bytes_i))
    else $error("output word changed while stalled");

  // an error word is empty, final and never completes the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != ST_OK) |->
      (byte_count_i == '0) && (out_bytes_i == '0) && last_of_run_i && !block_done_i)
    else $error("malformed error word");

  // a good word carries at least one byte and no more than a full word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_OK) |->
      (byte_count_i != '0) && (byte_count_i <= CNT_W'(OUT_WORD_BYTES)))
    else $error("byte count out of range");

  // only the final word of a run may be partly filled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_OK) && (byte_count_i != CNT_W'(OUT_WORD_BYTES)) |->
      last_of_run_i)
    else $error("partial word before end of run");

endmodule

bind lzjb_decompressor lzjb_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_bytes_i   (out_o.out_bytes),
  .byte_count_i  (out_o.byte_count),
  .last_of_run_i (out_o.last_of_run),
  .block_done_i  (out_o.block_done),
  .status_i      (out_o.status)
);
